@@ hw/rtl/slt_pkg.sv @@
// Types and codes shared by the service lifecycle ticket controller.
package slt_pkg;

    typedef enum logic [2:0] {
        PH_STOPPED   = 3'd0,
        PH_STARTING  = 3'd1,
        PH_RUNNING   = 3'd2,
        PH_STOPPING  = 3'd3,
        PH_EXITED    = 3'd4,
        PH_FAILED    = 3'd5,
        PH_EXHAUSTED = 3'd6
    } phase_t;

    typedef enum logic [2:0] {
        FN_RESERVE = 3'd0,
        FN_FAIL    = 3'd1,
        FN_PUBLISH = 3'd2,
        FN_STOP    = 3'd3,
        FN_EXIT    = 3'd4,
        FN_QUERY   = 3'd5
    } func_t;

    localparam logic [2:0] ST_REJECTED  = 3'd0;
    localparam logic [2:0] ST_DONE      = 3'd1;
    localparam logic [2:0] ST_ALREADY   = 3'd2;
    localparam logic [2:0] ST_STOPPING  = 3'd3;
    localparam logic [2:0] ST_EXHAUSTED = 3'd4;
    localparam logic [2:0] ST_CANCELLED = 3'd4;

    typedef struct packed {
        func_t       func;
        logic [63:0] ticket_identity;
        logic [31:0] ticket_generation;
        logic [31:0] instance_key;
    } evt_word_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] out_identity;
        logic [31:0] out_generation;
        logic [31:0] out_instance;
        phase_t      phase_now;
        logic        is_canonical;
        logic        start_is_current;
        logic        instance_is_current;
        logic        running_is_current;
    } res_word_t;

    typedef logic [63:0] cfg_word_t;

endpackage

@@ hw/rtl/slt_chan_if.sv @@
// Valid/ready channel carrying one word of a chosen payload type.
interface slt_chan_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ hw/rtl/service_lifecycle_ticket_fsm.sv @@
// Lifecycle controller for one supervised service.
//
// Takes one event word per cycle on evt while res is ready and returns one result
// word per event on res: the event sits in an input register, the phase update and the
// result are worked out from that register and the service state, and the result lands
// in an output register. The state is updated as the result is loaded, so back-to-back
// events see each other's effect and the sustained rate is one event per clock while res
// is ready. A stalled result holds the output register; the input register keeps
// accepting as long as the output register can be refilled. The cfg channel is always
// ready; a write of service_id reinitialises the phase, generation, instance and flags,
// and is to be issued only while no event is in flight.
module service_lifecycle_ticket_fsm #(
    parameter int GENERATION_BITS = 32,
    parameter int INSTANCE_BITS   = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    slt_chan_if.sink   cfg,
    slt_chan_if.sink   evt,
    slt_chan_if.source res
);
    import slt_pkg::*;

    localparam int GEN_W  = GENERATION_BITS;
    localparam int INST_W = INSTANCE_BITS;
    localparam int GEN_IN_W  = (GEN_W < 32) ? GEN_W : 32;
    localparam int INST_IN_W = (INST_W < 32) ? INST_W : 32;

    logic [63:0]       id_reg,    id_next;
    phase_t            phase_reg, phase_next;
    logic [GEN_W-1:0]  gen_reg,   gen_next;
    logic [INST_W-1:0] inst_reg,  inst_next;
    logic              want_reg,  want_next;
    logic              pend_reg,  pend_next;

    logic              s1_valid_reg, s1_valid_next;
    evt_word_t         s1_reg;
    logic              res_valid_reg, res_valid_next;
    res_word_t         res_reg,   res_next;

    logic              cfg_fire;
    logic              evt_fire;
    logic              res_load;

    logic [GEN_W-1:0]  tgen;
    logic [INST_W-1:0] key;
    logic              canon_now;
    logic              ticket_ok;
    logic              s_cur;
    logic              i_cur;
    logic              r_cur;
    logic              gen_at_max;

    function automatic logic canon_f(
        input logic              id_nz,
        input phase_t            ph,
        input logic [GEN_W-1:0]  g,
        input logic [INST_W-1:0] i,
        input logic              w,
        input logic              p
    );
        logic idle;
        logic ok;
        idle = (i == '0) && !w && !p;
        case (ph)
            PH_STOPPED:   ok = idle;
            PH_STARTING:  ok = (g != '0) && (i == '0) && w && p;
            PH_RUNNING:   ok = (g != '0) && (i != '0) && w && !p;
            PH_STOPPING:  ok = (g != '0) && (i != '0) && !w && !p;
            PH_EXITED,
            PH_FAILED:    ok = (g != '0) && idle;
            PH_EXHAUSTED: ok = (&g) && idle;
            default:      ok = 1'b0;
        endcase
        return id_nz && ok;
    endfunction

    assign cfg_fire  = cfg.valid && cfg.ready;
    assign evt_fire  = evt.valid && evt.ready;
    assign res_load  = s1_valid_reg && (!res_valid_reg || res.ready);
    assign cfg.ready = 1'b1;
    assign evt.ready = !s1_valid_reg || res_load;
    assign res.valid = res_valid_reg;
    assign res.payload = res_reg;

    assign tgen = GEN_W'(s1_reg.ticket_generation[GEN_IN_W-1:0]);
    assign key  = INST_W'(s1_reg.instance_key[INST_IN_W-1:0]);
    assign gen_at_max = &gen_reg;

    always_comb
    begin
        canon_now = canon_f(id_reg != '0, phase_reg, gen_reg, inst_reg, want_reg, pend_reg);
        ticket_ok = (s1_reg.ticket_identity != '0) && (tgen != '0) &&
                    (s1_reg.ticket_identity == id_reg) && (tgen == gen_reg);
        s_cur = canon_now && (phase_reg == PH_STARTING) && want_reg && pend_reg && ticket_ok;
        i_cur = (key != '0) && canon_now &&
                ((phase_reg == PH_RUNNING) || (phase_reg == PH_STOPPING)) &&
                (inst_reg == key) && ticket_ok;
        r_cur = (phase_reg == PH_RUNNING) && want_reg && i_cur;
    end

    always_comb
    begin
        id_next    = id_reg;
        phase_next = phase_reg;
        gen_next   = gen_reg;
        inst_next  = inst_reg;
        want_next  = want_reg;
        pend_next  = pend_reg;
        res_next   = res_reg;

        s1_valid_next = evt_fire ? 1'b1 : (res_load ? 1'b0 : s1_valid_reg);
        res_valid_next = res_load ? 1'b1 : (res.ready ? 1'b0 : res_valid_reg);

        if (res_load)
        begin
            res_next.status         = ST_REJECTED;
            res_next.out_identity   = '0;
            res_next.out_generation = '0;
            res_next.out_instance   = '0;

            case (s1_reg.func)
                FN_RESERVE:
                begin
                    if (!canon_now)
                    begin
                        res_next.status = ST_REJECTED;
                    end
                    else if (((phase_reg == PH_STARTING) && pend_reg) ||
                             ((phase_reg == PH_RUNNING) && want_reg))
                    begin
                        res_next.status = ST_ALREADY;
                    end
                    else if (phase_reg == PH_STOPPING)
                    begin
                        res_next.status = ST_STOPPING;
                    end
                    else if ((phase_reg == PH_EXHAUSTED) || gen_at_max)
                    begin
                        phase_next = PH_EXHAUSTED;
                        inst_next  = '0;
                        want_next  = 1'b0;
                        pend_next  = 1'b0;
                        res_next.status = ST_EXHAUSTED;
                    end
                    else
                    begin
                        gen_next   = gen_reg + GEN_W'(1);
                        phase_next = PH_STARTING;
                        inst_next  = '0;
                        want_next  = 1'b1;
                        pend_next  = 1'b1;
                        res_next.out_identity   = id_reg;
                        res_next.out_generation = 32'(gen_next[GEN_IN_W-1:0]);
                        res_next.status = ST_DONE;
                    end
                end
                FN_FAIL:
                begin
                    if (s_cur)
                    begin
                        phase_next = PH_FAILED;
                        inst_next  = '0;
                        want_next  = 1'b0;
                        pend_next  = 1'b0;
                        res_next.status = ST_DONE;
                    end
                end
                FN_PUBLISH:
                begin
                    if ((key != '0) && s_cur)
                    begin
                        phase_next = PH_RUNNING;
                        inst_next  = key;
                        want_next  = 1'b1;
                        pend_next  = 1'b0;
                        res_next.status = ST_DONE;
                    end
                end
                FN_STOP:
                begin
                    if (!canon_now)
                    begin
                        res_next.status = ST_REJECTED;
                    end
                    else if (phase_reg inside {PH_STOPPED, PH_EXITED, PH_FAILED,
                                               PH_EXHAUSTED})
                    begin
                        res_next.status = ST_ALREADY;
                    end
                    else if (phase_reg == PH_STOPPING)
                    begin
                        res_next.status = ST_STOPPING;
                    end
                    else if (phase_reg == PH_RUNNING)
                    begin
                        res_next.out_identity   = id_reg;
                        res_next.out_generation = 32'(gen_reg[GEN_IN_W-1:0]);
                        res_next.out_instance   = 32'(inst_reg[INST_IN_W-1:0]);
                        phase_next = PH_STOPPING;
                        want_next  = 1'b0;
                        pend_next  = 1'b0;
                        res_next.status = ST_DONE;
                    end
                    else
                    begin
                        phase_next = gen_at_max ? PH_EXHAUSTED : PH_STOPPED;
                        inst_next  = '0;
                        want_next  = 1'b0;
                        pend_next  = 1'b0;
                        res_next.status = ST_CANCELLED;
                    end
                end
                FN_EXIT:
                begin
                    if (i_cur)
                    begin
                        if (phase_reg == PH_STOPPING)
                        begin
                            phase_next = gen_at_max ? PH_EXHAUSTED : PH_STOPPED;
                        end
                        else
                        begin
                            phase_next = PH_EXITED;
                        end
                        inst_next = '0;
                        want_next = 1'b0;
                        pend_next = 1'b0;
                        res_next.status = ST_DONE;
                    end
                end
                default:
                begin
                    res_next.status = ST_REJECTED;
                end
            endcase

            res_next.phase_now           = phase_next;
            res_next.is_canonical        = canon_f(id_reg != '0, phase_next, gen_next,
                                                   inst_next, want_next, pend_next);
            res_next.start_is_current    = s_cur;
            res_next.instance_is_current = i_cur;
            res_next.running_is_current  = r_cur;
        end

        if (cfg_fire)
        begin
            id_next    = cfg.payload;
            phase_next = (cfg.payload != '0) ? PH_STOPPED : PH_EXHAUSTED;
            gen_next   = '0;
            inst_next  = '0;
            want_next  = 1'b0;
            pend_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_reg        <= '0;
            phase_reg     <= PH_EXHAUSTED;
            gen_reg       <= '0;
            inst_reg      <= '0;
            want_reg      <= 1'b0;
            pend_reg      <= 1'b0;
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            id_reg        <= id_next;
            phase_reg     <= phase_next;
            gen_reg       <= gen_next;
            inst_reg      <= inst_next;
            want_reg      <= want_next;
            pend_reg      <= pend_next;
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt_fire)
        begin
            s1_reg <= evt.payload;
        end
        res_reg <= res_next;
    end

`ifndef ASSERT_OFF
    a_cfg_reinit: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_fire |=> (gen_reg == '0) && (inst_reg == '0) && !want_reg && !pend_reg &&
                     (phase_reg == (($past(cfg.payload) != '0) ? PH_STOPPED : PH_EXHAUSTED)))
        else $error("service_id write did not reinitialise the state");

    a_gen_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        !cfg_fire |=> gen_reg >= $past(gen_reg))
        else $error("generation went backwards without a service_id write");

    a_mint_step: assert property (@(posedge clk) disable iff (!rst_n)
        (res_load && !cfg_fire && (s1_reg.func == FN_RESERVE) && (res_next.status == ST_DONE))
        |=> (gen_reg == $past(gen_reg) + GEN_W'(1)) && (phase_reg == PH_STARTING))
        else $error("minted ticket without a generation step");

    a_cur_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> !(res_reg.start_is_current && res_reg.instance_is_current) &&
                          (!res_reg.running_is_current || res_reg.instance_is_current))
        else $error("currency flags inconsistent");

    a_no_lost_word: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !res_load) |-> !evt.ready)
        else $error("event word accepted over a held one");
`endif

endmodule
